>>> hdl/hki_pkg.sv
// ----------------------------------------------------------------------------
// hki_pkg: shared types and constants of the digest keyed hash index
// Slot geometry, request and status codes, and the stored row layout.
// ----------------------------------------------------------------------------
package hki_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WORDS   = 8;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CAP_W       = 11;
  localparam int STRIDE_W    = 10;
  localparam int LOC_W       = 48;
  localparam int LEN_W       = 32;
  localparam int FOLD_W      = 64;
  localparam int MCNT_W      = $clog2(FOLD_W) + 1;

  typedef logic [SLOT_W-1:0]            slot_t;
  typedef logic [CAP_W-1:0]             cap_t;
  typedef logic [KEY_WORDS-1:0][31:0]   key_t;

  typedef struct packed {
    key_t             key;
    logic [LOC_W-1:0] loc;
    logic [LEN_W-1:0] len;
  } row_t;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_ERASE  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_STRIDE   = 1'b1;

  localparam cap_t        CAP_RESET    = 11'd4;
  localparam logic [9:0]  STRIDE_RESET = 10'd3;

  function automatic logic [FOLD_W-1:0] fold_key(key_t k);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = k[0] ^ k[1] ^ k[2] ^ k[3];
    lo = k[4] ^ k[5] ^ k[6] ^ k[7];
    return {hi, lo};
  endfunction

endpackage

>>> hdl/hki_if.sv
// ----------------------------------------------------------------------------
// hki_if: request and result channels of the hash index
// Valid/ready channels; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface hki_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] key_word_0;
  logic [31:0] key_word_1;
  logic [31:0] key_word_2;
  logic [31:0] key_word_3;
  logic [31:0] key_word_4;
  logic [31:0] key_word_5;
  logic [31:0] key_word_6;
  logic [31:0] key_word_7;
  logic [47:0] block_location;
  logic [31:0] block_length;

  modport source (output valid, req_type, key_word_0, key_word_1, key_word_2, key_word_3,
                  key_word_4, key_word_5, key_word_6, key_word_7, block_location,
                  block_length, input ready);
  modport sink (input valid, req_type, key_word_0, key_word_1, key_word_2, key_word_3,
                key_word_4, key_word_5, key_word_6, key_word_7, block_location,
                block_length, output ready);
endinterface

interface hki_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  slot_number;
  logic [47:0] found_location;
  logic [31:0] found_length;
  logic        duplicate_key;

  modport source (output valid, status, slot_number, found_location, found_length,
                  duplicate_key, input ready);
  modport sink (input valid, status, slot_number, found_location, found_length,
                duplicate_key, output ready);
endinterface

>>> hdl/digest_keyed_hash_index_core.sv
// ----------------------------------------------------------------------------
// digest_keyed_hash_index_core: open-addressed index keyed by a 256-bit digest
//
//   port      direction  contents
//   in_req    sink       request type, eight key words, location, length
//   out_res   source     status, slot, found location and length, duplicate
//   cfg_*     input      capacity (index 0) and probe stride (index 1)
//
// A request computes the home slot and then the step, both with the shared
// bit-serial remainder unit, then probes slot after slot through the single
// read port of the slot memory. Erase also moves each later cluster entry,
// recomputing its home slot and probing further slots for its new place.
// After reset a clearing pass empties the slot memory. A waiting result
// holds the next result back but not the next request.
// ----------------------------------------------------------------------------
module digest_keyed_hash_index_core (
  input  logic       clk,
  input  logic       rst_n,
  hki_in_if.sink     in_req,
  hki_out_if.source  out_res,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [10:0] cfg_wdata
);
  import hki_pkg::*;

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001, S_IDLE = 16'h0002, S_HGO = 16'h0004, S_HWT = 16'h0008,
    S_SGO   = 16'h0010, S_SWT  = 16'h0020, S_PRD = 16'h0040, S_PCK = 16'h0080,
    S_ERD   = 16'h0100, S_ECK  = 16'h0200, S_RGO = 16'h0400, S_RWT = 16'h0800,
    S_DRD   = 16'h1000, S_DCK  = 16'h2000, S_FIN = 16'h4000, S_SPARE = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        req_r;
  key_t              key_r;
  logic [LOC_W-1:0]  loc_r;
  logic [LEN_W-1:0]  len_r;
  cap_t              cap_r;
  logic [9:0]        stride_r;
  cap_t              capu;
  slot_t             step_r, idx_r, walk_r, dst_r, clr_r;
  cap_t              cnt_r, m_r, ent_r;
  row_t              mv_r, rrow;
  logic              dup_r;
  logic [1:0]        rs_status_r;
  slot_t             rs_slot_r;
  logic [LOC_W-1:0]  rs_loc_r;
  logic [LEN_W-1:0]  rs_len_r;
  logic              out_valid_r;
  logic [1:0]        o_status_r;
  logic [9:0]        o_slot_r;
  logic [LOC_W-1:0]  o_loc_r;
  logic [LEN_W-1:0]  o_len_r;
  logic              o_dup_r;

  logic              ram_we;
  slot_t             ram_waddr, ram_raddr;
  row_t              ram_wdata;
  logic [$bits(row_t)-1:0] ram_rdata;

  logic              mod_start;
  logic [FOLD_W-1:0] mod_div;
  logic [MCNT_W-1:0] mod_nbits;
  slot_t             mod_rem;
  logic              mod_done;
  logic              in_fire, key_hit, fin_load;
  key_t              in_key;

  function automatic slot_t next_slot(slot_t i, slot_t s, cap_t c);
    cap_t sum;
    sum = {1'b0, i} + {1'b0, s};
    if (sum >= c) begin
      sum = sum - c;
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign capu = (cap_r == '0) ? cap_t'(1) :
                (cap_r > cap_t'(TABLE_DEPTH)) ? cap_t'(TABLE_DEPTH) : cap_r;
  assign rrow     = row_t'(ram_rdata);
  assign key_hit  = (rrow.key == key_r);
  assign in_fire  = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_res.ready);
  assign in_key   = {in_req.key_word_7, in_req.key_word_6, in_req.key_word_5,
                     in_req.key_word_4, in_req.key_word_3, in_req.key_word_2,
                     in_req.key_word_1, in_req.key_word_0};

  hki_ram #(.WIDTH($bits(row_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hki_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_div),
    .nbits    (mod_nbits),
    .divisor  (capu),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_raddr = idx_r;
    mod_start = 1'b0;
    mod_div   = fold_key(key_r);
    mod_nbits = MCNT_W'(FOLD_W);
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == slot_t'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if ((in_req.req_type == REQ_INSERT && in_req.block_length == '0) ||
              (in_req.req_type != REQ_INSERT && in_req.req_type != REQ_LOOKUP &&
               in_req.req_type != REQ_ERASE)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_HGO;
          end
        end
      end
      S_HGO: begin
        mod_start = 1'b1;
        state_nxt = S_HWT;
      end
      S_HWT: if (mod_done) state_nxt = S_SGO;
      S_SGO: begin
        mod_start = 1'b1;
        mod_div   = {stride_r, {(FOLD_W - STRIDE_W){1'b0}}};
        mod_nbits = MCNT_W'(STRIDE_W);
        state_nxt = S_SWT;
      end
      S_SWT: if (mod_done) state_nxt = S_PRD;
      S_PRD: state_nxt = (cnt_r == capu) ? S_FIN : S_PCK;
      S_PCK: begin
        if (rrow.len == '0) begin
          if (req_r == REQ_INSERT) begin
            ram_we    = 1'b1;
            ram_wdata = '{key: key_r, loc: loc_r, len: len_r};
          end
          state_nxt = S_FIN;
        end else if (req_r != REQ_INSERT && key_hit) begin
          if (req_r == REQ_ERASE) begin
            ram_we    = 1'b1;
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_ERD: begin
        ram_raddr = next_slot(walk_r, step_r, capu);
        state_nxt = (cnt_r == capu) ? S_FIN : S_ECK;
      end
      S_ECK: begin
        if (rrow.len == '0) begin
          state_nxt = S_FIN;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = walk_r;
          state_nxt = S_RGO;
        end
      end
      S_RGO: begin
        mod_start = 1'b1;
        mod_div   = fold_key(mv_r.key);
        state_nxt = S_RWT;
      end
      S_RWT: if (mod_done) state_nxt = S_DRD;
      S_DRD: begin
        ram_raddr = dst_r;
        state_nxt = S_DCK;
      end
      S_DCK: begin
        ram_wdata = mv_r;
        if (rrow.len == '0) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          state_nxt = S_ERD;
        end else if (m_r == capu) begin
          ram_we    = 1'b1;
          ram_waddr = walk_r;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_FIN: if (fin_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ent_r       <= '0;
      cap_r       <= CAP_RESET;
      stride_r    <= STRIDE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + slot_t'(1);
      if (cfg_we && ent_r == '0) begin
        if (cfg_addr == CFG_CAPACITY) cap_r <= cfg_wdata;
        if (cfg_addr == CFG_STRIDE) stride_r <= cfg_wdata[STRIDE_W-1:0];
      end
      if (state_r == S_PCK && rrow.len == '0 && req_r == REQ_INSERT &&
          ent_r != '1) begin
        ent_r <= ent_r + cap_t'(1);
      end
      if (state_r == S_PCK && rrow.len != '0 && req_r == REQ_ERASE && key_hit &&
          ent_r != '0) begin
        ent_r <= ent_r - cap_t'(1);
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      o_status_r <= rs_status_r;
      o_slot_r   <= 10'(rs_slot_r);
      o_loc_r    <= rs_loc_r;
      o_len_r    <= rs_len_r;
      o_dup_r    <= dup_r;
    end
    unique case (state_r)
      S_IDLE: begin
        req_r       <= in_req.req_type;
        key_r       <= in_key;
        loc_r       <= in_req.block_location;
        len_r       <= in_req.block_length;
        dup_r       <= 1'b0;
        rs_slot_r   <= '0;
        rs_loc_r    <= '0;
        rs_len_r    <= '0;
        cnt_r       <= '0;
        rs_status_r <= (in_req.req_type == REQ_INSERT || in_req.req_type == REQ_LOOKUP ||
                        in_req.req_type == REQ_ERASE) ? ST_FULL : ST_NOTFOUND;
      end
      S_HWT: if (mod_done) idx_r <= mod_rem;
      S_SWT: if (mod_done) step_r <= (mod_rem == '0) ? slot_t'(1) : mod_rem;
      S_PCK: begin
        if (rrow.len == '0) begin
          if (req_r == REQ_INSERT) begin
            rs_status_r <= ST_DONE;
            rs_slot_r   <= idx_r;
          end else begin
            rs_status_r <= ST_NOTFOUND;
          end
        end else if (req_r != REQ_INSERT && key_hit) begin
          rs_status_r <= ST_DONE;
          rs_slot_r   <= idx_r;
          rs_loc_r    <= rrow.loc;
          rs_len_r    <= rrow.len;
          walk_r      <= idx_r;
          cnt_r       <= '0;
        end else begin
          if (req_r == REQ_INSERT && key_hit) dup_r <= 1'b1;
          idx_r <= next_slot(idx_r, step_r, capu);
          cnt_r <= cnt_r + cap_t'(1);
        end
      end
      S_ERD: begin
        walk_r <= next_slot(walk_r, step_r, capu);
        cnt_r  <= cnt_r + cap_t'(1);
      end
      S_ECK: mv_r <= rrow;
      S_RWT: begin
        if (mod_done) begin
          dst_r <= mod_rem;
          m_r   <= '0;
        end
      end
      S_DCK: begin
        dst_r <= next_slot(dst_r, step_r, capu);
        m_r   <= m_r + cap_t'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = o_status_r;
  assign out_res.slot_number    = o_slot_r;
  assign out_res.found_location = o_loc_r;
  assign out_res.found_length   = o_len_r;
  assign out_res.duplicate_key  = o_dup_r;

endmodule

>>> hdl/hki_ram.sv
// ----------------------------------------------------------------------------
// hki_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hki_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/hki_mod_unit.sv
// ----------------------------------------------------------------------------
// hki_mod_unit: bit-serial remainder unit
// Reduces the top nbits of a 64-bit value modulo the capacity, one bit a cycle.
// ----------------------------------------------------------------------------
module hki_mod_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hki_pkg::FOLD_W-1:0] dividend,
  input  logic [hki_pkg::MCNT_W-1:0] nbits,
  input  hki_pkg::cap_t             divisor,
  output hki_pkg::slot_t            rem,
  output logic                      done
);
  import hki_pkg::*;

  logic [FOLD_W-1:0] sh_r;
  slot_t             rem_r;
  logic [MCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  cap_t              trial;
  cap_t              reduced;

  always_comb begin
    trial   = {rem_r, sh_r[FOLD_W-1]};
    reduced = (trial >= divisor) ? trial - divisor : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == MCNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      cnt_r <= nbits;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[FOLD_W-2:0], 1'b0};
      cnt_r <= cnt_r - MCNT_W'(1);
      rem_r <= reduced[SLOT_W-1:0];
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> tb/sv/hki_checker.sv
// ----------------------------------------------------------------------------
// hki_checker: result predictor and scoreboard for the digest keyed hash index
// Watches the request, result and register ports. It keeps its own copy of the
// slot table and the registers, predicts one result per accepted request and
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hki_checker (
  input  logic        clk,
  input  logic        rst_n,
  hki_in_if           in_req,
  hki_out_if          out_res,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata,
  input  logic        end_check,
  output int          fail_count
);
  import hki_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    slot_t            slot;
    logic [LOC_W-1:0] loc;
    logic [LEN_W-1:0] len;
    logic             dup;
  } index_result_t;

  index_result_t    pending_results[$];
  key_t             tbl_key [TABLE_DEPTH];
  logic [LOC_W-1:0] tbl_loc [TABLE_DEPTH];
  logic [LEN_W-1:0] tbl_len [TABLE_DEPTH];
  int unsigned      n_entries;
  cap_t             cur_cap;
  logic [9:0]       cur_stride;
  int               mismatches;
  bit               tail_done;

  assign fail_count = mismatches;

  function automatic int unsigned slots_in_use();
    int unsigned c;
    c = cur_cap;
    if (c == 0) c = 1;
    if (c > TABLE_DEPTH) c = TABLE_DEPTH;
    return c;
  endfunction

  function automatic int unsigned next_slot(int unsigned idx, int unsigned cap);
    int unsigned s;
    s = cur_stride % cap;
    if (s == 0) s = 1;
    return (idx + s) % cap;
  endfunction

  function automatic int unsigned home_slot(key_t k, int unsigned cap);
    logic [63:0] folded;
    logic [63:0] cap64;
    folded = {k[0] ^ k[1] ^ k[2] ^ k[3], k[4] ^ k[5] ^ k[6] ^ k[7]};
    cap64  = cap;
    return int'(folded % cap64);
  endfunction

  function automatic index_result_t predict_index(logic [1:0] req, key_t k,
                                                  logic [LOC_W-1:0] bloc,
                                                  logic [LEN_W-1:0] blen);
    index_result_t    r;
    int unsigned      cap, idx, n, walk, dst, m;
    bit               placed, hit;
    key_t             mk;
    logic [LOC_W-1:0] ml;
    logic [LEN_W-1:0] mlen;
    r = '0;
    cap = slots_in_use();
    placed = 0;
    hit = 0;
    if (req == REQ_INSERT) begin
      if (blen == 0) begin
        r.status = ST_FULL;
      end else begin
        idx = home_slot(k, cap);
        for (n = 0; n < cap; n++) begin
          if (tbl_len[idx] == 0) begin
            placed = 1;
            break;
          end
          if (tbl_key[idx] == k) r.dup = 1'b1;
          idx = next_slot(idx, cap);
        end
        if (placed) begin
          tbl_key[idx] = k;
          tbl_loc[idx] = bloc;
          tbl_len[idx] = blen;
          if (n_entries < 2047) n_entries++;
          r.slot = slot_t'(idx);
        end else begin
          r.status = ST_FULL;
        end
      end
    end else if (req == REQ_LOOKUP || req == REQ_ERASE) begin
      idx = home_slot(k, cap);
      for (n = 0; n < cap; n++) begin
        if (tbl_len[idx] == 0) begin
          placed = 1;
          break;
        end
        if (tbl_key[idx] == k) begin
          hit = 1;
          break;
        end
        idx = next_slot(idx, cap);
      end
      if (hit) begin
        r.slot = slot_t'(idx);
        r.loc  = tbl_loc[idx];
        r.len  = tbl_len[idx];
        if (req == REQ_ERASE) begin
          walk = idx;
          tbl_len[idx] = 0;
          if (n_entries > 0) n_entries--;
          for (n = 0; n < cap; n++) begin
            walk = next_slot(walk, cap);
            if (tbl_len[walk] == 0) break;
            mk   = tbl_key[walk];
            ml   = tbl_loc[walk];
            mlen = tbl_len[walk];
            tbl_len[walk] = 0;
            dst = home_slot(mk, cap);
            for (m = 0; m < cap; m++) begin
              if (tbl_len[dst] == 0) break;
              dst = next_slot(dst, cap);
            end
            if (tbl_len[dst] != 0) dst = walk;
            tbl_key[dst] = mk;
            tbl_loc[dst] = ml;
            tbl_len[dst] = mlen;
          end
        end
      end else if (placed) begin
        r.status = ST_NOTFOUND;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      r.status = ST_NOTFOUND;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    index_result_t exp_r;
    index_result_t got_r;
    key_t          k;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        tbl_len[i] = '0;
        tbl_loc[i] = '0;
        tbl_key[i] = '0;
      end
      n_entries  = 0;
      cur_cap    = CAP_RESET;
      cur_stride = STRIDE_RESET;
      mismatches = 0;
      tail_done  = 0;
      pending_results.delete();
    end else begin
      if (cfg_we && n_entries == 0) begin
        if (cfg_addr == CFG_CAPACITY) cur_cap = cfg_wdata;
        else cur_stride = cfg_wdata[9:0];
      end
      if (out_res.valid && out_res.ready) begin
        got_r = '{out_res.status, out_res.slot_number, out_res.found_location,
                  out_res.found_length, out_res.duplicate_key};
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: status %0d slot %0d", got_r.status,
                     got_r.slot);
          mismatches++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r.status !== exp_r.status || got_r.slot !== exp_r.slot ||
              got_r.loc !== exp_r.loc || got_r.len !== exp_r.len ||
              got_r.dup !== exp_r.dup) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected status %0d slot %0d loc %h len %h dup %b",
                       exp_r.status, exp_r.slot, exp_r.loc, exp_r.len, exp_r.dup);
              $display("                 actual   status %0d slot %0d loc %h len %h dup %b",
                       got_r.status, got_r.slot, got_r.loc, got_r.len, got_r.dup);
            end
            mismatches++;
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        k = {in_req.key_word_7, in_req.key_word_6, in_req.key_word_5, in_req.key_word_4,
             in_req.key_word_3, in_req.key_word_2, in_req.key_word_1, in_req.key_word_0};
        pending_results.push_back(predict_index(in_req.req_type, k, in_req.block_location,
                                                in_req.block_length));
      end
      if (end_check && !tail_done) begin
        tail_done = 1;
        if (pending_results.size() != 0) begin
          $display("%0d results never arrived", pending_results.size());
          mismatches += pending_results.size();
        end
      end
    end
  end

endmodule

>>> tb/sv/digest_keyed_hash_index_core_tb.sv
// ----------------------------------------------------------------------------
// digest_keyed_hash_index_core_tb: stimulus and verdict for the hash index
// Runs a directed sequence on the reset geometry, then phases of random
// inserts, lookups and erases over small key pools with forced collisions,
// across capacity and stride settings. Each phase empties the table first.
// ----------------------------------------------------------------------------
module digest_keyed_hash_index_core_tb;
  import hki_pkg::*;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int         CYCLE_LIMIT  = 3000000;
  localparam int         POOL_MAX     = 64;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [10:0] cfg_wdata;
  logic        end_check;
  int          fail_count;

  hki_in_if  in_req ();
  hki_out_if out_res ();

  digest_keyed_hash_index_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  hki_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .end_check (end_check),
    .fail_count(fail_count)
  );

  int unsigned sent_cnt;
  int unsigned recv_cnt;
  int unsigned cycle_cnt;
  bit          no_idle;
  key_t        key_pool [POOL_MAX];
  int unsigned insert_cnt [POOL_MAX];
  int unsigned pool_n;
  int unsigned live_cap;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  assign no_idle = (sent_cnt >= 600 && sent_cnt < 950);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_res.ready <= no_idle || ($urandom_range(99) >= 12);
    if (rst_n && out_res.valid && out_res.ready) recv_cnt <= recv_cnt + 1;
  end

  function automatic key_t random_key();
    key_t k;
    for (int i = 0; i < KEY_WORDS; i++) k[i] = $urandom;
    return k;
  endfunction

  function automatic logic [47:0] random_loc();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic key_t same_home_key(key_t k);
    logic [31:0] x;
    x = $urandom;
    k[0] ^= x;
    k[1] ^= x;
    return k;
  endfunction

  task automatic send_req(logic [1:0] req, key_t k, logic [47:0] loc, logic [31:0] len);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 12) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.req_type       <= req;
    in_req.key_word_0     <= k[0];
    in_req.key_word_1     <= k[1];
    in_req.key_word_2     <= k[2];
    in_req.key_word_3     <= k[3];
    in_req.key_word_4     <= k[4];
    in_req.key_word_5     <= k[5];
    in_req.key_word_6     <= k[6];
    in_req.key_word_7     <= k[7];
    in_req.block_location <= loc;
    in_req.block_length   <= len;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic insert_pool(int unsigned i, logic [47:0] loc, logic [31:0] len);
    send_req(REQ_INSERT, key_pool[i], loc, len);
    if (len != 0) insert_cnt[i]++;
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (sent_cnt != recv_cnt);
  endtask

  task automatic write_geometry(cap_t cap, logic [9:0] stride);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_addr  <= CFG_STRIDE;
    cfg_wdata <= {1'b0, stride};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic empty_table();
    int unsigned n;
    drain();
    for (int i = 0; i < pool_n; i++) begin
      n = (insert_cnt[i] < live_cap) ? insert_cnt[i] : live_cap;
      repeat (n) send_req(REQ_ERASE, key_pool[i], random_loc(), $urandom);
      insert_cnt[i] = 0;
    end
    drain();
  endtask

  task automatic run_phase(cap_t cap, logic [9:0] stride, int items);
    int unsigned i, r;
    logic [31:0] len;
    key_t        k;
    empty_table();
    write_geometry(cap, stride);
    live_cap = (cap == 0) ? 1 : ((cap > TABLE_DEPTH) ? TABLE_DEPTH : cap);
    pool_n = (live_cap < 16) ? live_cap + 3 : 24;
    for (int j = 0; j < pool_n; j++) begin
      key_pool[j]   = (j % 3 != 0) ? same_home_key(key_pool[j - (j % 3)]) : random_key();
      insert_cnt[j] = 0;
    end
    repeat (items) begin
      i = $urandom_range(pool_n - 1);
      r = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? random_key() : key_pool[i];
      if (r < 45) begin
        len = ($urandom_range(99) < 3) ? 32'd0 : $urandom;
        insert_pool(i, random_loc(), len);
      end else if (r < 72) begin
        send_req(REQ_LOOKUP, k, random_loc(), $urandom);
      end else if (r < 95) begin
        send_req(REQ_ERASE, k, random_loc(), $urandom);
      end else begin
        send_req(REQ_RESERVED, random_key(), random_loc(), $urandom);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_req.valid   <= 1'b0;
    in_req.req_type <= REQ_INSERT;
    in_req.key_word_0 <= '0;
    in_req.key_word_1 <= '0;
    in_req.key_word_2 <= '0;
    in_req.key_word_3 <= '0;
    in_req.key_word_4 <= '0;
    in_req.key_word_5 <= '0;
    in_req.key_word_6 <= '0;
    in_req.key_word_7 <= '0;
    in_req.block_location <= '0;
    in_req.block_length   <= '0;
    cfg_we         <= 1'b0;
    cfg_addr       <= CFG_CAPACITY;
    cfg_wdata      <= '0;
    end_check      <= 1'b0;
    sent_cnt       = 0;
    live_cap       = CAP_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pool_n      = 6;
    key_pool[0] = random_key();
    key_pool[1] = same_home_key(key_pool[0]);
    key_pool[2] = same_home_key(key_pool[0]);
    key_pool[3] = '1;
    key_pool[4] = '0;
    key_pool[5] = random_key();
    for (int j = 0; j < pool_n; j++) insert_cnt[j] = 0;

    insert_pool(0, random_loc(), $urandom);
    insert_pool(0, random_loc(), $urandom);
    send_req(REQ_LOOKUP, key_pool[0], '0, '0);
    send_req(REQ_LOOKUP, key_pool[5], '0, '0);
    send_req(REQ_ERASE, key_pool[5], '0, '0);
    insert_pool(3, '1, '1);
    insert_pool(4, '0, 32'd1);
    insert_pool(1, random_loc(), $urandom);
    send_req(REQ_LOOKUP, key_pool[1], '1, '1);
    send_req(REQ_ERASE, key_pool[1], '1, '1);
    insert_pool(2, random_loc(), 32'd0);
    send_req(REQ_RESERVED, '1, '1, '1);
    send_req(REQ_ERASE, key_pool[0], '0, '0);
    send_req(REQ_LOOKUP, key_pool[0], '0, '0);
    send_req(REQ_LOOKUP, key_pool[3], '0, '0);
    send_req(REQ_ERASE, key_pool[3], '0, '0);
    insert_pool(1, random_loc(), $urandom);
    insert_pool(2, random_loc(), $urandom);
    send_req(REQ_ERASE, key_pool[1], '0, '0);
    send_req(REQ_LOOKUP, key_pool[2], '0, '0);
    drain();
    write_geometry(11'd1, 10'd1);
    send_req(REQ_LOOKUP, key_pool[2], '0, '0);
    send_req(REQ_ERASE, key_pool[4], '0, '0);

    run_phase(11'd1,    10'd1,    130);
    run_phase(11'd0,    10'd5,    90);
    run_phase(11'd2,    10'd1,    130);
    run_phase(11'd7,    10'd3,    150);
    run_phase(11'd16,   10'd5,    150);
    run_phase(11'd8,    10'd0,    130);
    run_phase(11'd5,    10'd1023, 130);
    run_phase(11'd1024, 10'd1023, 150);
    run_phase(11'd1023, 10'd1000, 130);
    run_phase(11'd2047, 10'd1,    110);
    run_phase(CAP_RESET, STRIDE_RESET, 90);
    empty_table();

    end_check <= 1'b1;
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/hki_pkg.sv
hdl/hki_if.sv
hdl/hki_ram.sv
hdl/hki_mod_unit.sv
hdl/digest_keyed_hash_index_core.sv
tb/sv/hki_checker.sv
tb/sv/digest_keyed_hash_index_core_tb.sv
